@@ hdl/vpma_pkg.sv @@
// ----------------------------------------------------------------------------
// vpma_pkg
// Shared types, register codes and plane helpers for the planar video memory.
// ----------------------------------------------------------------------------
package vpma_pkg;

    // store geometry
    localparam int STORE_WORDS_DEF = 65536;
    localparam int ADDR_W          = 17;
    localparam int CFG_IDX_W       = 3;

    // window bases and span
    localparam logic [ADDR_W-1:0] WIN_HIGH_LIMIT = 17'h0FFFF;
    localparam logic [ADDR_W-1:0] WIN_B0_BASE    = 17'h10000;
    localparam logic [ADDR_W-1:0] WIN_B8_BASE    = 17'h18000;
    localparam logic [ADDR_W-1:0] WIN_SPAN_MASK  = 17'h07FFF;

    // configuration register index
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SET_RESET    = 3'd0,
        REG_COMPARE      = 3'd1,
        REG_ROTATE_LOGIC = 3'd2,
        REG_READ_PLANE   = 3'd3,
        REG_ACCESS_MODES = 3'd4,
        REG_BIT_MASK     = 3'd5,
        REG_PLANE_WE     = 3'd6,
        REG_MEM_LAYOUT   = 3'd7
    } cfg_index_t;

    // map window select
    typedef enum logic [1:0] {
        WIN_ALL = 2'd0,
        WIN_A0  = 2'd1,
        WIN_B0  = 2'd2,
        WIN_B8  = 2'd3
    } window_t;

    // memory mode (codes two and three both mean chain-4)
    typedef enum logic [1:0] {
        MAP_ODD_EVEN = 2'd0,
        MAP_PLANAR   = 2'd1,
        MAP_CHAIN4   = 2'd2,
        MAP_CHAIN4_B = 2'd3
    } map_mode_t;

    // planar write modes
    typedef enum logic [1:0] {
        WM_ROTATE  = 2'd0,
        WM_LATCH   = 2'd1,
        WM_COLOR   = 2'd2,
        WM_SR_MASK = 2'd3
    } write_mode_t;

    // logic operation with the latch
    typedef enum logic [1:0] {
        LOP_NONE = 2'd0,
        LOP_AND  = 2'd1,
        LOP_OR   = 2'd2,
        LOP_XOR  = 2'd3
    } logic_op_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_WRITE = 2'd3
    } state_t;

    // each nibble bit becomes a full plane byte
    function automatic logic [31:0] expand_nibble(input logic [3:0] n);
        logic [31:0] r;
        for (int p = 0; p < 4; p++)
        begin
            r[8*p +: 8] = {8{n[p]}};
        end
        return r;
    endfunction

    function automatic logic [31:0] spread_byte(input logic [7:0] b);
        return {b, b, b, b};
    endfunction

    function automatic logic [7:0] rotate_byte(input logic [7:0] b, input logic [2:0] cnt);
        logic [15:0] w;
        w = {b, b} >> cnt;
        return w[7:0];
    endfunction

    function automatic logic [31:0] apply_logic(input logic [31:0] planes,
                                                input logic [31:0] latch,
                                                input logic [1:0]  op);
        logic [31:0] r;
        case (logic_op_t'(op))
            LOP_AND:  r = planes & latch;
            LOP_OR:   r = planes | latch;
            LOP_XOR:  r = planes ^ latch;
            default:  r = planes;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] merge_mask(input logic [31:0] planes,
                                               input logic [31:0] latch,
                                               input logic [7:0]  mask);
        logic [31:0] wide;
        wide = spread_byte(mask);
        return (planes & wide) | (latch & ~wide);
    endfunction

endpackage

@@ hdl/vga_planar_memory_access.sv @@
// ----------------------------------------------------------------------------
// vga_planar_memory_access
// CPU view of four-plane video memory: byte reads and writes through the
// map window, odd/even, planar and chain-4 layouts, read and write modes.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir | word
//  ---------+-------------------------------------------+-----+---------------------------
//  in       | in_valid, in_stall, kind, address,        | in  | one byte read or write
//           | write_data                                |     |
//  out      | out_valid, out_stall, read_data           | out | byte returned by a read
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | one register write
//
//  an in-window read or write reads the store, then sends the result out or
//  writes the merged word back; an out-of-window read returns 0xFF and an
//  out-of-window write is dropped. after reset a clearing pass zeroes the
//  store word by word, with no access taken; configuration writes are always taken.
//  a read waits in place while the output register is full and stalled.
// ----------------------------------------------------------------------------
module vga_planar_memory_access #(
    parameter int STORE_WORDS = vpma_pkg::STORE_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // access channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           kind,
    input  logic [vpma_pkg::ADDR_W-1:0]    address,
    input  logic [7:0]                     write_data,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     read_data,
    // configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vpma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    import vpma_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [19:0] SW1 = 20'(STORE_WORDS);
    localparam logic [19:0] SW2 = 20'(2 * STORE_WORDS);
    localparam logic [19:0] SW4 = 20'(4 * STORE_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(STORE_WORDS - 1);

    // configuration registers
    logic [7:0] set_reset_reg;
    logic [7:0] compare_reg;
    logic [4:0] rot_logic_reg;
    logic [1:0] read_plane_reg;
    logic [2:0] access_modes_reg;
    logic [7:0] bit_mask_reg;
    logic [3:0] plane_we_reg;
    logic [3:0] layout_reg;

    // control and item registers
    state_t      state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [31:0] latch_reg, latch_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  read_data_reg, read_data_next;
    logic        hit_reg;
    logic        rmode_reg;
    logic        planar_reg;
    logic [1:0]  plane_reg;
    logic [3:0]  enable_reg;
    logic [AW-1:0] word_reg;
    logic [7:0]  data_reg;

    // decode of the incoming access
    logic              in_accept;
    logic              dec_hit;
    logic [ADDR_W-1:0] dec_off;
    logic [ADDR_W-1:0] dec_word_full;
    logic [19:0]       wrap_v;
    logic [AW-1:0]     dec_word;
    logic [1:0]        dec_plane;
    logic              dec_rmode;
    logic [3:0]        dec_enable;
    map_mode_t         mode;

    // store ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [31:0]   ram_q;

    // datapath values
    logic [7:0]  rd_result;
    logic [31:0] cmp_t;
    logic [31:0] wr_planes;
    logic [31:0] wr_wide;
    logic [7:0]  rot_byte;
    logic [31:0] sr_planes;
    logic        out_free;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign cfg_ready = 1'b1;
    assign mode      = map_mode_t'(layout_reg[3:2]);
    assign out_free  = !out_valid_reg || !out_stall;

    // window check and offset
    always_comb
    begin
        dec_hit = 1'b1;
        dec_off = address;
        case (window_t'(layout_reg[1:0]))
            WIN_ALL:
            begin
                dec_hit = 1'b1;
                dec_off = address;
            end
            WIN_A0:
            begin
                dec_hit = (address <= WIN_HIGH_LIMIT);
                dec_off = address;
            end
            WIN_B0:
            begin
                dec_hit = (address >= WIN_B0_BASE) && (address < WIN_B8_BASE);
                dec_off = (address - WIN_B0_BASE) & WIN_SPAN_MASK;
            end
            WIN_B8:
            begin
                dec_hit = (address >= WIN_B8_BASE);
                dec_off = (address - WIN_B8_BASE) & WIN_SPAN_MASK;
            end
            default:
            begin
                dec_hit = 1'b0;
                dec_off = address;
            end
        endcase
    end

    // word address, plane and enables per memory mode
    always_comb
    begin
        dec_rmode = 1'b0;
        case (mode)
            MAP_ODD_EVEN:
            begin
                dec_word_full = dec_off >> 1;
                dec_plane     = {read_plane_reg[1], dec_off[0]};
                dec_enable    = (4'b0101 << dec_off[0]) & plane_we_reg;
            end
            MAP_PLANAR:
            begin
                dec_word_full = dec_off;
                dec_plane     = read_plane_reg;
                dec_rmode     = access_modes_reg[2];
                dec_enable    = plane_we_reg;
            end
            default:
            begin
                dec_word_full = dec_off >> 2;
                dec_plane     = dec_off[1:0];
                dec_enable    = (4'b0001 << dec_off[1:0]) & plane_we_reg;
            end
        endcase
    end

    // wrap word address into the store, value stays below eight store sizes
    always_comb
    begin
        wrap_v = {3'b000, dec_word_full};
        if (wrap_v >= SW4)
        begin
            wrap_v = wrap_v - SW4;
        end
        if (wrap_v >= SW2)
        begin
            wrap_v = wrap_v - SW2;
        end
        if (wrap_v >= SW1)
        begin
            wrap_v = wrap_v - SW1;
        end
        dec_word = wrap_v[AW-1:0];
    end

    // read result: plane byte or colour compare
    always_comb
    begin
        cmp_t = (ram_q ^ ~expand_nibble(compare_reg[3:0])) | ~expand_nibble(compare_reg[7:4]);
        if (rmode_reg)
        begin
            rd_result = cmp_t[31:24] & cmp_t[23:16] & cmp_t[15:8] & cmp_t[7:0];
        end
        else
        begin
            rd_result = ram_q[8*plane_reg +: 8];
        end
    end

    // write data path
    always_comb
    begin
        rot_byte  = rotate_byte(data_reg, rot_logic_reg[2:0]);
        sr_planes = (spread_byte(rot_byte) & ~expand_nibble(set_reset_reg[7:4]))
                  | expand_nibble(set_reset_reg[7:4] & set_reset_reg[3:0]);
        if (!planar_reg)
        begin
            wr_planes = spread_byte(data_reg);
        end
        else
        begin
            case (write_mode_t'(access_modes_reg[1:0]))
                WM_ROTATE:
                begin
                    wr_planes = merge_mask(apply_logic(sr_planes, latch_reg, rot_logic_reg[4:3]),
                                           latch_reg, bit_mask_reg);
                end
                WM_LATCH:
                begin
                    wr_planes = latch_reg;
                end
                WM_COLOR:
                begin
                    wr_planes = merge_mask(apply_logic(expand_nibble(data_reg[3:0]), latch_reg,
                                                       rot_logic_reg[4:3]),
                                           latch_reg, bit_mask_reg);
                end
                default:
                begin
                    wr_planes = merge_mask(apply_logic(expand_nibble(set_reset_reg[3:0]),
                                                       latch_reg, rot_logic_reg[4:3]),
                                           latch_reg, rot_byte & bit_mask_reg);
                end
            endcase
        end
        wr_wide = expand_nibble(enable_reg);
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, store controls and result
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        latch_next     = latch_reg;
        out_valid_next = out_valid_reg && out_stall;
        read_data_next = read_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = word_reg;
        ram_wdata      = (ram_q & ~wr_wide) | (wr_planes & wr_wide);
        ram_re         = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    ram_re = dec_hit;
                    if (!kind)
                    begin
                        state_next = ST_READ;
                    end
                    else if (dec_hit)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = hit_reg ? rd_result : 8'hFF;
                    if (hit_reg)
                    begin
                        latch_next = ram_q;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                ram_we     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            latch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        if (in_accept)
        begin
            hit_reg    <= dec_hit;
            rmode_reg  <= dec_rmode;
            planar_reg <= (mode == MAP_PLANAR);
            plane_reg  <= dec_plane;
            enable_reg <= dec_enable;
            word_reg   <= dec_word;
            data_reg   <= write_data;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reset_reg    <= 8'd0;
            compare_reg      <= 8'd240;
            rot_logic_reg    <= 5'd0;
            read_plane_reg   <= 2'd0;
            access_modes_reg <= 3'd0;
            bit_mask_reg     <= 8'd255;
            plane_we_reg     <= 4'd15;
            layout_reg       <= 4'd5;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SET_RESET:    set_reset_reg    <= cfg_data;
                REG_COMPARE:      compare_reg      <= cfg_data;
                REG_ROTATE_LOGIC: rot_logic_reg    <= cfg_data[4:0];
                REG_READ_PLANE:   read_plane_reg   <= cfg_data[1:0];
                REG_ACCESS_MODES: access_modes_reg <= cfg_data[2:0];
                REG_BIT_MASK:     bit_mask_reg     <= cfg_data;
                REG_PLANE_WE:     plane_we_reg     <= cfg_data[3:0];
                REG_MEM_LAYOUT:   layout_reg       <= cfg_data[3:0];
                default:          ;
            endcase
        end
    end

    // plane store
    vpma_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dec_word),
        .rdata (ram_q)
    );

    // store written only by the clearing pass or a write-back
    a_store_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WRITE))
        else $error("store written outside clear or write-back");

    // a new result comes only from the read state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_READ)
        else $error("result raised without a read");

    // the latch changes only when a read completes
    a_latch_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(latch_reg) |-> $past(state_reg) == ST_READ && $past(hit_reg))
        else $error("latch changed outside a read");

    // a write-back always follows a store read issued on accept
    a_write_follows: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WRITE |-> $past(ram_re) && $past(in_accept))
        else $error("write-back without preceding read");

endmodule

@@ hdl/vpma_ram.sv @@
// ----------------------------------------------------------------------------
// vpma_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vpma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ verif/vga_planar_memory_access_test.sv @@
// ----------------------------------------------------------------------------
// vga_planar_memory_access_test
// Self-checking bench for the planar video memory. Byte reads and writes go
// in through the access channel with random gaps and result stalls. A shadow
// copy of the four planes, the latch and the control registers predicts
// every read byte, and each returned word is checked in order.
// ----------------------------------------------------------------------------
module vga_planar_memory_access_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vpma_pkg::*;

    localparam int STORE_DEPTH     = STORE_WORDS_DEF;
    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_PHASES   = 16;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam bit KIND_READ       = 1'b0;
    localparam bit KIND_WRITE      = 1'b1;

    typedef struct packed {
        bit        kind;
        bit [16:0] addr;
        bit [7:0]  data;
    } access_t;

    typedef struct packed {
        bit [16:0] addr;
        bit [7:0]  data;
    } read_expect_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 kind       = 1'b0;
    logic [ADDR_W-1:0]    address    = '0;
    logic [7:0]           write_data = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [7:0]           read_data;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [7:0]           cfg_data   = '0;

    // shadow of the control registers
    bit [7:0] sr_bits   = 8'd0;
    bit [7:0] cmp_bits  = 8'd240;
    bit [4:0] rot_logic = 5'd0;
    bit [1:0] rd_plane  = 2'd0;
    bit [2:0] acc_modes = 3'd0;
    bit [7:0] mask_bits = 8'hFF;
    bit [3:0] plane_we  = 4'hF;
    bit [3:0] layout    = 4'd5;

    // shadow of the planes and the latch
    bit [31:0] plane_latch = '0;
    bit [31:0] plane_mem [STORE_DEPTH];

    access_t      pending_access [$];
    read_expect_t expected_reads [$];

    int       max_gap        = 8;
    int       max_stall      = 8;
    int       gap_left       = 0;
    int       stall_left     = 0;
    int       results_seen   = 0;
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    bit [9:0] focus_seed     = '0;

    vga_planar_memory_access #(
        .STORE_WORDS(STORE_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .address    (address),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // one 0xFF byte per selected plane
    function automatic bit [31:0] byte_mask(input bit [3:0] sel);
        bit [31:0] r;
        r = '0;
        for (int p = 0; p < 4; p++)
        begin
            if (sel[p])
                r[8*p +: 8] = 8'hFF;
        end
        return r;
    endfunction

    function automatic bit [7:0] rot_right(input bit [7:0] v);
        bit [15:0] w;
        w = {v, v} >> rot_logic[2:0];
        return w[7:0];
    endfunction

    function automatic bit [31:0] with_latch(input bit [31:0] planes);
        case (logic_op_t'(rot_logic[4:3]))
            LOP_AND: return planes & plane_latch;
            LOP_OR:  return planes | plane_latch;
            LOP_XOR: return planes ^ plane_latch;
            default: return planes;
        endcase
    endfunction

    function automatic bit [31:0] mask_merge(input bit [31:0] planes, input bit [7:0] m);
        bit [31:0] wide;
        wide = {4{m}};
        return (planes & wide) | (plane_latch & ~wide);
    endfunction

    // one access against the shadow planes; reads report the byte returned
    function automatic void predict_access(input bit is_write, input bit [16:0] addr,
                                           input bit [7:0] val, output bit has_byte,
                                           output bit [7:0] rd_byte);
        bit          in_win;
        bit [16:0]   off;
        bit [1:0]    plane;
        bit [3:0]    enable;
        bit [31:0]   planes;
        bit [31:0]   wide;
        bit [31:0]   t;
        int unsigned word_idx;
        map_mode_t   mode;
        has_byte = !is_write;
        rd_byte  = 8'hFF;
        mode     = map_mode_t'(layout[3:2]);
        off      = addr;
        // map window
        case (window_t'(layout[1:0]))
            WIN_ALL: in_win = 1'b1;
            WIN_A0:  in_win = addr <= WIN_HIGH_LIMIT;
            WIN_B0:
            begin
                off    = addr - WIN_B0_BASE;
                in_win = addr >= WIN_B0_BASE && off <= WIN_SPAN_MASK;
            end
            default:
            begin
                off    = addr - WIN_B8_BASE;
                in_win = addr >= WIN_B8_BASE && off <= WIN_SPAN_MASK;
            end
        endcase
        if (!in_win)
            return;
        // word address and planes for the memory mode
        case (mode)
            MAP_ODD_EVEN:
            begin
                word_idx = 32'(off >> 1);
                plane    = {rd_plane[1], off[0]};
                enable   = (4'b0101 << off[0]) & plane_we;
            end
            MAP_PLANAR:
            begin
                word_idx = 32'(off);
                plane    = rd_plane;
                enable   = plane_we;
            end
            default:
            begin
                word_idx = 32'(off >> 2);
                plane    = off[1:0];
                enable   = (4'b0001 << off[1:0]) & plane_we;
            end
        endcase
        word_idx = word_idx % STORE_DEPTH;
        // reads load the latch
        if (!is_write)
        begin
            plane_latch = plane_mem[word_idx];
            if (mode == MAP_PLANAR && acc_modes[2])
            begin
                t = (plane_latch ^ ~byte_mask(cmp_bits[3:0])) | ~byte_mask(cmp_bits[7:4]);
                rd_byte = t[31:24] & t[23:16] & t[15:8] & t[7:0];
            end
            else
                rd_byte = plane_latch[8*plane +: 8];
            return;
        end
        // writes
        if (mode != MAP_PLANAR)
            planes = {4{val}};
        else
        begin
            case (write_mode_t'(acc_modes[1:0]))
                WM_ROTATE:
                begin
                    planes = {4{rot_right(val)}};
                    planes = (planes & ~byte_mask(sr_bits[7:4]))
                             | byte_mask(sr_bits[7:4] & sr_bits[3:0]);
                    planes = mask_merge(with_latch(planes), mask_bits);
                end
                WM_LATCH:
                    planes = plane_latch;
                WM_COLOR:
                    planes = mask_merge(with_latch(byte_mask(val[3:0])), mask_bits);
                default:
                    planes = mask_merge(with_latch(byte_mask(sr_bits[3:0])),
                                        rot_right(val) & mask_bits);
            endcase
        end
        wide = byte_mask(enable);
        plane_mem[word_idx] = (plane_mem[word_idx] & ~wide) | (planes & wide);
    endfunction

    // access driver
    always @(posedge clk or negedge rst_n)
    begin : drive_access
        access_t      next_acc;
        read_expect_t exp_rd;
        bit           has_byte;
        bit [7:0]     rd_byte;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            kind       <= 1'b0;
            address    <= '0;
            write_data <= '0;
            gap_left   <= 0;
        end
        else
        begin
            // accepted word updates the shadow state
            if (in_valid && !in_stall)
            begin
                predict_access(kind, address, write_data, has_byte, rd_byte);
                if (has_byte)
                begin
                    exp_rd.addr = address;
                    exp_rd.data = rd_byte;
                    expected_reads.push_back(exp_rd);
                end
            end
            // a stalled word holds
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_access.size() != 0)
                begin
                    next_acc = pending_access.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= next_acc.kind;
                    address    <= next_acc.addr;
                    write_data <= next_acc.data;
                    gap_left   <= $urandom_range(0, max_gap);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall driver
    always @(posedge clk or negedge rst_n)
    begin : sink_results
        read_expect_t want;
        int           n;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_reads.size() == 0)
                    report_mismatch($sformatf("read_data %02h with no read outstanding",
                                              read_data));
                else
                begin
                    want = expected_reads.pop_front();
                    if (read_data !== want.data)
                        report_mismatch($sformatf("read of %05h gave %02h, expected %02h",
                                                  want.addr, read_data, want.data));
                end
                // long hold-off twice in the run so the block backs up
                if (results_seen == 150 || results_seen == 700)
                    n = HOLD_OFF_CYCLES;
                else
                    n = $urandom_range(0, max_stall);
                stall_left <= n;
                out_stall  <= (n != 0);
            end
            else if (stall_left > 1)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else
            begin
                stall_left <= 0;
                out_stall  <= 1'b0;
            end
        end
    end

    task automatic queue_access(input bit k, input bit [16:0] a, input bit [7:0] d);
        access_t acc;
        acc.kind = k;
        acc.addr = a;
        acc.data = d;
        pending_access.push_back(acc);
    endtask

    // wait for the block to go idle, checked away from the active edge
    task automatic wait_drained();
        @(negedge clk);
        while (pending_access.size() != 0 || in_valid || expected_reads.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input bit [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SET_RESET:    sr_bits   = val;
            REG_COMPARE:      cmp_bits  = val;
            REG_ROTATE_LOGIC: rot_logic = val[4:0];
            REG_READ_PLANE:   rd_plane  = val[1:0];
            REG_ACCESS_MODES: acc_modes = val[2:0];
            REG_BIT_MASK:     mask_bits = val;
            REG_PLANE_WE:     plane_we  = val[3:0];
            default:          layout    = val[3:0];
        endcase
    endtask

    // mostly a small hot region inside the window, plus edges and noise
    function automatic bit [16:0] pick_address();
        int unsigned base;
        int unsigned span;
        bit [16:0]   a;
        case (window_t'(layout[1:0]))
            WIN_ALL:
            begin
                base = 0;
                span = 32'h20000;
            end
            WIN_A0:
            begin
                base = 0;
                span = 32'h10000;
            end
            WIN_B0:
            begin
                base = 32'(WIN_B0_BASE);
                span = WIN_SPAN_MASK + 1;
            end
            default:
            begin
                base = 32'(WIN_B8_BASE);
                span = WIN_SPAN_MASK + 1;
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
                a = 17'(base + ((span - 64) * focus_seed) / 1024 + $urandom_range(0, 63));
            6, 7:
                a = 17'($urandom_range(0, 32'h1FFFF));
            8:
                a = 17'($urandom_range(0, 1) ? base : base + span - 1);
            default:
                a = 17'($urandom_range(0, 1) ? base - 1 : base + span);
        endcase
        return a;
    endfunction

    task automatic run_random_phase(input int phase);
        int        target;
        int        added;
        bit [16:0] a;
        map_mode_t mode;
        bit [7:0]  regs [8];
        // register setting for this phase
        if (phase == 0)
        begin
            foreach (regs[i])
                regs[i] = 8'h00;
        end
        else if (phase == 1)
        begin
            foreach (regs[i])
                regs[i] = 8'hFF;
        end
        else
        begin
            foreach (regs[i])
                regs[i] = 8'($urandom_range(0, 255));
            case (phase % 6)
                0:       mode = MAP_ODD_EVEN;
                2:       mode = MAP_CHAIN4;
                4:       mode = MAP_CHAIN4_B;
                default: mode = MAP_PLANAR;
            endcase
            regs[REG_MEM_LAYOUT]   = {4'b0, mode, regs[REG_MEM_LAYOUT][1:0]};
            regs[REG_ACCESS_MODES] = {5'b0, regs[REG_ACCESS_MODES][2],
                                      2'((phase >> 1) % 4)};
        end
        for (int i = 0; i < 8; i++)
            write_reg(cfg_index_t'(i), regs[i]);
        focus_seed = 10'($urandom);
        max_gap    = (phase % 4 == 3 || phase % 5 == 2) ? 0 : 8;
        max_stall  = (phase % 4 == 3) ? 0 : 8;
        // mostly read-modify-write pairs with random content
        target = $urandom_range(90, 120);
        added  = 0;
        while (added < target)
        begin
            a = pick_address();
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    queue_access(KIND_READ, a, 8'($urandom));
                    queue_access(KIND_WRITE, a, 8'($urandom));
                    added += 2;
                end
                4, 5:
                begin
                    queue_access(KIND_READ, a, 8'($urandom));
                    added++;
                end
                default:
                begin
                    queue_access(KIND_WRITE, a, 8'($urandom));
                    added++;
                end
            endcase
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset layout: planar, low 64K window; outside accesses ignored
        queue_access(KIND_WRITE, 17'h00000, 8'hA5);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        queue_access(KIND_WRITE, 17'h0FFFF, 8'hFF);
        queue_access(KIND_READ,  17'h0FFFF, 8'hFF);
        queue_access(KIND_WRITE, 17'h10000, 8'h3C);
        queue_access(KIND_READ,  17'h10000, 8'h00);
        queue_access(KIND_READ,  17'h1FFFF, 8'hFF);
        wait_drained();

        // whole window, planar: upper half wraps onto the store
        write_reg(REG_MEM_LAYOUT, {4'b0, MAP_PLANAR, WIN_ALL});
        queue_access(KIND_WRITE, 17'h10000, 8'h5A);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        queue_access(KIND_READ,  17'h1FFFF, 8'h00);
        wait_drained();

        // odd/even in the B0 window
        write_reg(REG_MEM_LAYOUT, {4'b0, MAP_ODD_EVEN, WIN_B0});
        write_reg(REG_READ_PLANE, 8'd2);
        queue_access(KIND_WRITE, 17'h10001, 8'h81);
        queue_access(KIND_READ,  17'h10001, 8'h00);
        queue_access(KIND_READ,  17'h10000, 8'h00);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        wait_drained();

        // chain-4 in the B8 window
        write_reg(REG_MEM_LAYOUT, {4'b0, MAP_CHAIN4, WIN_B8});
        queue_access(KIND_WRITE, 17'h18003, 8'h7E);
        queue_access(KIND_READ,  17'h18003, 8'h00);
        queue_access(KIND_READ,  17'h17FFF, 8'h00);
        wait_drained();

        // write mode three with xor, then colour compare read
        write_reg(REG_MEM_LAYOUT, {4'b0, MAP_PLANAR, WIN_ALL});
        write_reg(REG_ACCESS_MODES, {6'b0, WM_SR_MASK});
        write_reg(REG_ROTATE_LOGIC, {3'b0, LOP_XOR, 3'd3});
        write_reg(REG_SET_RESET, 8'h0C);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        queue_access(KIND_WRITE, 17'h00000, 8'hFF);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        wait_drained();
        write_reg(REG_ACCESS_MODES, {5'b0, 1'b1, WM_SR_MASK});
        write_reg(REG_COMPARE, 8'hF5);
        queue_access(KIND_READ,  17'h00000, 8'h00);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
            run_random_phase(phase);

        if (expected_reads.size() != 0)
            report_mismatch($sformatf("%0d reads never returned", expected_reads.size()));
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ vga_planar_memory_access.f @@
hdl/vpma_pkg.sv
hdl/vpma_ram.sv
hdl/vga_planar_memory_access.sv
verif/vga_planar_memory_access_test.sv
